[sv/lbtt_pkg.sv]
// Shared types and constants for the LED blink and timeout ticker.
// Used by every module of the block; depends on nothing.
package lbtt_pkg;

  // Operation codes of an input transaction
  typedef enum logic [2:0] {
    OP_TICK             = 3'd0,
    OP_RESTART          = 3'd1,
    OP_RELOAD_KEEPALIVE = 3'd2,
    OP_RELOAD_BATTERY   = 3'd3,
    OP_RELOAD_SPEED     = 3'd4,
    OP_RELOAD_KEY       = 3'd5,
    OP_RELOAD_VOLTAGE   = 3'd6
  } op_t;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_LED0_ON_TIME    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LED0_CYCLE_TIME = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LED1_ON_TIME    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LED1_CYCLE_TIME = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LED2_ON_TIME    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LED2_CYCLE_TIME = 3'd5;

  // Channels that have timing registers and show up in led_states
  localparam int unsigned REG_CHANNELS = 3;
  localparam int unsigned DIV_W        = 7;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] reload_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] led_states;
    logic       second_pulse;
    logic       shutdown_request;
    logic [7:0] keepalive_left;
    logic [7:0] battery_wait_left;
    logic [7:0] speed_left;
    logic [7:0] key_left;
    logic [7:0] voltage_left;
  } out_item_t;

  // Per-transaction control shared by all LED channels
  typedef struct packed {
    logic tick;
    logic restart;
    logic shutdown;
  } chan_ctl_t;

  // Seconds event flags from the seconds unit
  typedef struct packed {
    logic pulse;
    logic shutdown;
  } sec_status_t;

  typedef struct packed {
    logic [7:0] keepalive;
    logic [7:0] battery_wait;
    logic [7:0] speed;
    logic [7:0] key;
    logic [7:0] voltage;
  } sec_counts_t;

endpackage

[sv/lbtt_led_channel.sv]
// One blinking LED channel: on-time and cycle countdowns plus the lit flag.
// Depends on lbtt_pkg for the control struct.
module lbtt_led_channel (
  input  logic                 clk,
  input  logic                 rst,
  input  lbtt_pkg::chan_ctl_t  ctl,
  input  logic [7:0]           on_time,
  input  logic [7:0]           cycle_time,
  output logic                 lit_next
);

  logic [7:0] on_cd;
  logic [7:0] cyc_cd;
  logic       lit;
  logic [7:0] on_cd_next;
  logic [7:0] cyc_cd_next;

  logic [7:0] on_start;
  logic [7:0] cyc_start;
  logic       lit_start;
  logic       on_expired;
  logic       cyc_expired;
  logic [7:0] on_mid;
  logic       lit_mid;

  // Compute the channel state after this transaction
  always_comb begin
    on_start  = ctl.restart ? 8'd0 : on_cd;
    cyc_start = ctl.restart ? 8'd0 : cyc_cd;
    lit_start = ctl.shutdown ? 1'b0 : lit;

    // on-time runs out at one or when already empty
    on_expired = (on_start <= 8'd1);
    on_mid     = on_expired ? 8'd1 : on_start - 8'd1;
    lit_mid    = on_expired ? 1'b0 : lit_start;

    // cycle end reloads both counts and lights a non-zero on-time
    cyc_expired = (cyc_start <= 8'd1);
    if (cyc_expired) begin
      cyc_cd_next = cycle_time;
      on_cd_next  = on_time;
      lit_next    = (on_time != 8'd0) ? 1'b1 : lit_mid;
    end else begin
      cyc_cd_next = cyc_start - 8'd1;
      on_cd_next  = on_mid;
      lit_next    = lit_mid;
    end

    // hold everything on non-tick transactions
    if (!ctl.tick) begin
      cyc_cd_next = cyc_cd;
      on_cd_next  = on_cd;
      lit_next    = lit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_cd  <= 8'd0;
      cyc_cd <= 8'd0;
      lit    <= 1'b0;
    end else begin
      on_cd  <= on_cd_next;
      cyc_cd <= cyc_cd_next;
      lit    <= lit_next;
    end
  end

endmodule

[sv/lbtt_seconds.sv]
// Tick divider and the five seconds counters with their reloads.
// Depends on lbtt_pkg for op codes and count/status structs.
module lbtt_seconds #(
  parameter int unsigned TICKS_PER_SECOND  = 100,
  parameter int unsigned KEEPALIVE_SECONDS = 240,
  parameter int unsigned REPORT_INTERVAL   = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  lbtt_pkg::in_item_t     item,
  output lbtt_pkg::sec_counts_t  counts_next,
  output lbtt_pkg::sec_status_t  status
);

  localparam logic [lbtt_pkg::DIV_W-1:0] DIV_RELOAD =
    lbtt_pkg::DIV_W'(TICKS_PER_SECOND);
  localparam logic [7:0] KA_RESET  = 8'(KEEPALIVE_SECONDS);
  localparam logic [7:0] BAT_RESET = 8'(KEEPALIVE_SECONDS / 4);
  localparam logic [7:0] RPT_RESET = 8'(REPORT_INTERVAL);

  logic [lbtt_pkg::DIV_W-1:0] tick_divider;
  logic [lbtt_pkg::DIV_W-1:0] tick_divider_next;
  logic [lbtt_pkg::DIV_W-1:0] div_dec;
  lbtt_pkg::sec_counts_t      counts;

  function automatic logic [7:0] stop_at_zero(input logic [7:0] v);
    return (v != 8'd0) ? v - 8'd1 : 8'd0;
  endfunction

  // Advance the divider on ticks, apply reloads on reload transactions
  always_comb begin
    counts_next       = counts;
    tick_divider_next = tick_divider;
    status            = '0;
    div_dec           = tick_divider - 1'b1;
    if (fire) begin
      case (item.op)
        lbtt_pkg::OP_TICK: begin
          tick_divider_next = div_dec;
          if (div_dec == '0) begin
            status.pulse             = 1'b1;
            counts_next.keepalive    = counts.keepalive - 8'd1;
            status.shutdown          = (counts_next.keepalive == 8'd0);
            counts_next.battery_wait = stop_at_zero(counts.battery_wait);
            counts_next.speed        = stop_at_zero(counts.speed);
            counts_next.key          = stop_at_zero(counts.key);
            counts_next.voltage      = stop_at_zero(counts.voltage);
            tick_divider_next        = DIV_RELOAD;
          end
        end
        lbtt_pkg::OP_RELOAD_KEEPALIVE: counts_next.keepalive    = item.reload_value;
        lbtt_pkg::OP_RELOAD_BATTERY:   counts_next.battery_wait = item.reload_value;
        lbtt_pkg::OP_RELOAD_SPEED:     counts_next.speed        = item.reload_value;
        lbtt_pkg::OP_RELOAD_KEY:       counts_next.key          = item.reload_value;
        lbtt_pkg::OP_RELOAD_VOLTAGE:   counts_next.voltage      = item.reload_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_divider        <= DIV_RELOAD;
      counts.keepalive    <= KA_RESET;
      counts.battery_wait <= BAT_RESET;
      counts.speed        <= RPT_RESET;
      counts.key          <= RPT_RESET;
      counts.voltage      <= RPT_RESET;
    end else begin
      tick_divider <= tick_divider_next;
      counts       <= counts_next;
    end
  end

endmodule

[sv/led_blink_and_timeout_ticker.sv]
// Top level of the LED blink and timeout ticker: input register, config
// registers, LED channels, seconds unit and result register.
// Depends on lbtt_pkg, lbtt_led_channel and lbtt_seconds.
//
//   channel | signals                         | moves
//   --------+---------------------------------+---------------------------
//   item    | item_valid, item_stall, item    | op and reload value in
//   result  | result_valid, result_stall, ... | LED states and counts out
//   cfg     | cfg_valid, cfg_ready, cfg_index | LED timing register write
//
// One transaction per cycle sustained unless the result stalls; each item
// passes the input register, then the result register. State updates when a
// transaction moves from the input register into the result register.
// Synchronous reset restores counters, clears LEDs and config registers and
// arms a phase restart for the first tick. A stalled result holds the input
// register, and item_stall rises only while both stages are full.
module led_blink_and_timeout_ticker #(
  parameter int unsigned TICKS_PER_SECOND  = 100,
  parameter int unsigned KEEPALIVE_SECONDS = 240,
  parameter int unsigned REPORT_INTERVAL   = 1,
  parameter int unsigned LED_CHANNELS      = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  lbtt_pkg::in_item_t                  item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output lbtt_pkg::out_item_t                 result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lbtt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [7:0]                          cfg_data
);

  logic                  s1_valid;
  lbtt_pkg::in_item_t    s1_item;
  logic                  advance;
  logic                  fire;
  logic                  restart_pending;
  logic [7:0]            on_time    [lbtt_pkg::REG_CHANNELS];
  logic [7:0]            cycle_time [lbtt_pkg::REG_CHANNELS];
  lbtt_pkg::chan_ctl_t   chan_ctl;
  lbtt_pkg::sec_status_t sec_status;
  lbtt_pkg::sec_counts_t sec_counts_next;
  logic [LED_CHANNELS-1:0] lit_next;
  logic [2:0]            led_states_next;

  // Handshake: result register frees when empty or taken
  assign advance    = !result_valid || !result_stall;
  assign fire       = s1_valid && advance;
  assign item_stall = s1_valid && !advance;
  assign cfg_ready  = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbtt_pkg::REG_CHANNELS; i++) begin
        on_time[i]    <= 8'd0;
        cycle_time[i] <= 8'd0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbtt_pkg::REG_LED0_ON_TIME:    on_time[0]    <= cfg_data;
        lbtt_pkg::REG_LED0_CYCLE_TIME: cycle_time[0] <= cfg_data;
        lbtt_pkg::REG_LED1_ON_TIME:    on_time[1]    <= cfg_data;
        lbtt_pkg::REG_LED1_CYCLE_TIME: cycle_time[1] <= cfg_data;
        lbtt_pkg::REG_LED2_ON_TIME:    on_time[2]    <= cfg_data;
        lbtt_pkg::REG_LED2_CYCLE_TIME: cycle_time[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pending phase restart: set by a restart, consumed by the next tick
  always_ff @(posedge clk) begin
    if (rst) begin
      restart_pending <= 1'b1;
    end else if (fire) begin
      if (s1_item.op == lbtt_pkg::OP_RESTART) begin
        restart_pending <= 1'b1;
      end else if (s1_item.op == lbtt_pkg::OP_TICK) begin
        restart_pending <= 1'b0;
      end
    end
  end

  lbtt_seconds #(
    .TICKS_PER_SECOND  (TICKS_PER_SECOND),
    .KEEPALIVE_SECONDS (KEEPALIVE_SECONDS),
    .REPORT_INTERVAL   (REPORT_INTERVAL)
  ) u_seconds (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .item        (s1_item),
    .counts_next (sec_counts_next),
    .status      (sec_status)
  );

  assign chan_ctl.tick     = fire && (s1_item.op == lbtt_pkg::OP_TICK);
  assign chan_ctl.restart  = restart_pending;
  assign chan_ctl.shutdown = sec_status.shutdown;

  // LED channels; those without registers run with zero times
  for (genvar ch = 0; ch < LED_CHANNELS; ch++) begin : g_chan
    logic [7:0] ch_on_time;
    logic [7:0] ch_cycle_time;
    if (ch < lbtt_pkg::REG_CHANNELS) begin : g_reg
      assign ch_on_time    = on_time[ch];
      assign ch_cycle_time = cycle_time[ch];
    end else begin : g_zero
      assign ch_on_time    = 8'd0;
      assign ch_cycle_time = 8'd0;
    end
    lbtt_led_channel u_chan (
      .clk        (clk),
      .rst        (rst),
      .ctl        (chan_ctl),
      .on_time    (ch_on_time),
      .cycle_time (ch_cycle_time),
      .lit_next   (lit_next[ch])
    );
  end

  // Only the first three channels are reported
  for (genvar b = 0; b < 3; b++) begin : g_led_bit
    if (b < LED_CHANNELS) begin : g_on
      assign led_states_next[b] = lit_next[b];
    end else begin : g_off
      assign led_states_next[b] = 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (advance) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result.led_states        <= led_states_next;
      result.second_pulse      <= sec_status.pulse;
      result.shutdown_request  <= sec_status.shutdown;
      result.keepalive_left    <= sec_counts_next.keepalive;
      result.battery_wait_left <= sec_counts_next.battery_wait;
      result.speed_left        <= sec_counts_next.speed;
      result.key_left          <= sec_counts_next.key;
      result.voltage_left      <= sec_counts_next.voltage;
    end
  end

endmodule

[tb/lbtt_checker.sv]
// Scoreboard for the LED blink and timeout ticker: watches the item, result
// and cfg channels, predicts each result and compares it field by field.
// Depends on lbtt_pkg.
`timescale 1ns / 1ps

module lbtt_checker #(
  parameter int unsigned TICKS_PER_SECOND  = 100,
  parameter int unsigned KEEPALIVE_SECONDS = 240,
  parameter int unsigned REPORT_INTERVAL   = 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  lbtt_pkg::in_item_t               item,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  lbtt_pkg::out_item_t              result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lbtt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  output int                               mismatches,
  output int                               waiting,
  output int                               seconds_seen,
  output int                               shutdowns_seen
);

  localparam int unsigned LED_REGS = 2 * lbtt_pkg::REG_CHANNELS;
  localparam int unsigned REPORT_LIMIT = 10;

  // Predicted block state
  logic [7:0]                          led_time [LED_REGS];
  logic [lbtt_pkg::DIV_W-1:0]          div_count;
  logic [7:0]                          keepalive_cnt;
  logic [7:0]                          battery_cnt;
  logic [7:0]                          speed_cnt;
  logic [7:0]                          key_cnt;
  logic [7:0]                          voltage_cnt;
  logic [7:0]                          on_cnt  [lbtt_pkg::REG_CHANNELS];
  logic [7:0]                          cyc_cnt [lbtt_pkg::REG_CHANNELS];
  logic [lbtt_pkg::REG_CHANNELS-1:0]   lit;
  logic                                phase_restart;

  lbtt_pkg::out_item_t pending_results [$];
  int fail_total;
  int second_total;
  int shutdown_total;

  function automatic logic [7:0] count_down_sat(input logic [7:0] v);
    return (v != 8'd0) ? v - 8'd1 : 8'd0;
  endfunction

  function automatic string describe(input lbtt_pkg::out_item_t r);
    return $sformatf("leds=%b sec=%b shut=%b ka=%0d bat=%0d spd=%0d key=%0d volt=%0d",
                     r.led_states, r.second_pulse, r.shutdown_request, r.keepalive_left,
                     r.battery_wait_left, r.speed_left, r.key_left, r.voltage_left);
  endfunction

  // Advance every LED channel by one tick
  task automatic blink_channels();
    logic [7:0] on_t;
    logic [7:0] cyc_t;
    logic       done;
    if (phase_restart) begin
      for (int i = 0; i < lbtt_pkg::REG_CHANNELS; i++) begin
        on_cnt[i]  = 8'd0;
        cyc_cnt[i] = 8'd0;
      end
      phase_restart = 1'b0;
    end
    for (int i = 0; i < lbtt_pkg::REG_CHANNELS; i++) begin
      on_t  = led_time[2*i];
      cyc_t = led_time[2*i+1];
      // on-time expiry turns the LED off
      if (on_cnt[i] == 8'd0) begin
        done = 1'b1;
      end else begin
        on_cnt[i] = on_cnt[i] - 8'd1;
        done = (on_cnt[i] == 8'd0);
      end
      if (done) begin
        lit[i]    = 1'b0;
        on_cnt[i] = 8'd1;
      end
      // cycle end reloads both counts and lights the LED for a non-zero on-time
      if (cyc_cnt[i] == 8'd0) begin
        done = 1'b1;
      end else begin
        cyc_cnt[i] = cyc_cnt[i] - 8'd1;
        done = (cyc_cnt[i] == 8'd0);
      end
      if (done) begin
        cyc_cnt[i] = cyc_t;
        on_cnt[i]  = on_t;
        if (on_t != 8'd0) lit[i] = 1'b1;
      end
    end
  endtask

  // Apply one transaction to the predicted state and form its result
  task automatic step_ticker(input lbtt_pkg::in_item_t it, output lbtt_pkg::out_item_t res);
    logic pulse;
    logic shut;
    pulse = 1'b0;
    shut  = 1'b0;
    case (it.op)
      lbtt_pkg::OP_TICK: begin
        div_count = div_count - 1'b1;
        if (div_count == '0) begin
          pulse = 1'b1;
          keepalive_cnt = keepalive_cnt - 8'd1;
          if (keepalive_cnt == 8'd0) begin
            shut = 1'b1;
            lit  = '0;
          end
          battery_cnt = count_down_sat(battery_cnt);
          speed_cnt   = count_down_sat(speed_cnt);
          key_cnt     = count_down_sat(key_cnt);
          voltage_cnt = count_down_sat(voltage_cnt);
          div_count   = lbtt_pkg::DIV_W'(TICKS_PER_SECOND);
        end
        blink_channels();
      end
      lbtt_pkg::OP_RESTART:          phase_restart = 1'b1;
      lbtt_pkg::OP_RELOAD_KEEPALIVE: keepalive_cnt = it.reload_value;
      lbtt_pkg::OP_RELOAD_BATTERY:   battery_cnt   = it.reload_value;
      lbtt_pkg::OP_RELOAD_SPEED:     speed_cnt     = it.reload_value;
      lbtt_pkg::OP_RELOAD_KEY:       key_cnt       = it.reload_value;
      lbtt_pkg::OP_RELOAD_VOLTAGE:   voltage_cnt   = it.reload_value;
      default: ;
    endcase
    res.led_states        = lit;
    res.second_pulse      = pulse;
    res.shutdown_request  = shut;
    res.keepalive_left    = keepalive_cnt;
    res.battery_wait_left = battery_cnt;
    res.speed_left        = speed_cnt;
    res.key_left          = key_cnt;
    res.voltage_left      = voltage_cnt;
  endtask

  always @(posedge clk) begin : track
    lbtt_pkg::out_item_t want;
    logic                bad;
    if (rst) begin
      for (int i = 0; i < LED_REGS; i++) led_time[i] = 8'd0;
      for (int i = 0; i < lbtt_pkg::REG_CHANNELS; i++) begin
        on_cnt[i]  = 8'd0;
        cyc_cnt[i] = 8'd0;
      end
      div_count      = lbtt_pkg::DIV_W'(TICKS_PER_SECOND);
      keepalive_cnt  = 8'(KEEPALIVE_SECONDS);
      battery_cnt    = 8'(KEEPALIVE_SECONDS / 4);
      speed_cnt      = 8'(REPORT_INTERVAL);
      key_cnt        = 8'(REPORT_INTERVAL);
      voltage_cnt    = 8'(REPORT_INTERVAL);
      lit            = '0;
      phase_restart  = 1'b1;
      fail_total     = 0;
      second_total   = 0;
      shutdown_total = 0;
      pending_results.delete();
    end else begin
      // track register writes
      if (cfg_valid && cfg_ready && cfg_index < LED_REGS) led_time[cfg_index] = cfg_data;

      // compare each result transaction with the oldest prediction
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          if (fail_total < REPORT_LIMIT)
            $display("%0t: unexpected result, got %s", $realtime, describe(result));
          fail_total++;
        end else begin
          want = pending_results.pop_front();
          bad = (result.led_states        !== want.led_states)        ||
                (result.second_pulse      !== want.second_pulse)      ||
                (result.shutdown_request  !== want.shutdown_request)  ||
                (result.keepalive_left    !== want.keepalive_left)    ||
                (result.battery_wait_left !== want.battery_wait_left) ||
                (result.speed_left        !== want.speed_left)        ||
                (result.key_left          !== want.key_left)          ||
                (result.voltage_left      !== want.voltage_left);
          if (bad) begin
            if (fail_total < REPORT_LIMIT) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(result));
            end
            fail_total++;
          end
        end
      end

      // predict each accepted item transaction
      if (item_valid && !item_stall) begin
        step_ticker(item, want);
        if (want.second_pulse) second_total++;
        if (want.shutdown_request) shutdown_total++;
        pending_results.push_back(want);
      end
    end
    mismatches     <= fail_total;
    waiting        <= pending_results.size();
    seconds_seen   <= second_total;
    shutdowns_seen <= shutdown_total;
  end

endmodule

[tb/led_blink_and_timeout_ticker_tb.sv]
// Testbench top for the LED blink and timeout ticker: clock, reset, item and
// cfg stimulus, result back-pressure and the verdict.
// Depends on lbtt_pkg, led_blink_and_timeout_ticker and lbtt_checker.
`timescale 1ns / 1ps

module led_blink_and_timeout_ticker_tb;

  localparam int unsigned TICKS_PER_SECOND  = 100;
  localparam int unsigned KEEPALIVE_SECONDS = 240;
  localparam int unsigned REPORT_INTERVAL   = 1;
  localparam int unsigned LED_CHANNELS      = 3;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_PER_PHASE = 350;
  localparam int DRAIN_CYCLES     = 4;
  localparam int HOLD_OFF_CYCLES  = 80;
  localparam int LIMIT_CYCLES     = 200000;

  logic                             clk;
  logic                             rst;
  logic                             item_valid;
  logic                             item_stall;
  lbtt_pkg::in_item_t               item;
  logic                             result_valid;
  logic                             result_stall;
  lbtt_pkg::out_item_t              result;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [lbtt_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]                       cfg_data;

  int  mismatches;
  int  waiting;
  int  seconds_seen;
  int  shutdowns_seen;
  int  cycles;
  int  items_sent;
  bit  calm;
  bit  hold_off_req;
  bit  hold_off_done;

  led_blink_and_timeout_ticker #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .KEEPALIVE_SECONDS(KEEPALIVE_SECONDS),
    .REPORT_INTERVAL  (REPORT_INTERVAL),
    .LED_CHANNELS     (LED_CHANNELS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  lbtt_checker #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND),
    .KEEPALIVE_SECONDS(KEEPALIVE_SECONDS),
    .REPORT_INTERVAL  (REPORT_INTERVAL)
  ) scoreboard (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .waiting       (waiting),
    .seconds_seen  (seconds_seen),
    .shutdowns_seen(shutdowns_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Count cycles and stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, waiting);
        $display("** led_blink_and_timeout_ticker: FAILED **");
        $finish;
      end
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    hold_off_done = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        result_stall <= !calm && ($urandom_range(99) < 10);
      end
    end
  end

  function automatic lbtt_pkg::in_item_t make_item(input logic [2:0] op,
                                                   input logic [7:0] value);
    lbtt_pkg::in_item_t it;
    it.op           = op;
    it.reload_value = value;
    return it;
  endfunction

  // Mostly ticks; keepalive reloads lean small so shutdowns and wraps occur
  function automatic lbtt_pkg::in_item_t random_item();
    lbtt_pkg::in_item_t it;
    int unsigned        r;
    r = $urandom_range(99);
    it.reload_value = 8'($urandom_range(255));
    if (r < 75) begin
      it.op = lbtt_pkg::OP_TICK;
    end else if (r < 80) begin
      it.op = lbtt_pkg::OP_RESTART;
    end else if (r < 97) begin
      if (r < 87) it.op = lbtt_pkg::OP_RELOAD_KEEPALIVE;
      else        it.op = 3'($urandom_range(lbtt_pkg::OP_RELOAD_VOLTAGE,
                                            lbtt_pkg::OP_RELOAD_BATTERY));
      if ($urandom_range(1)) it.reload_value = 8'($urandom_range(3));
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  // Offer one item transaction, hold it until accepted
  task automatic push_item(input lbtt_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < 10) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic write_reg(input logic [lbtt_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Drain the block, then load all six LED timing registers
  task automatic configure_leds(input logic [7:0] on0, input logic [7:0] cyc0,
                                input logic [7:0] on1, input logic [7:0] cyc1,
                                input logic [7:0] on2, input logic [7:0] cyc2);
    item_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(lbtt_pkg::REG_LED0_ON_TIME, on0);
    write_reg(lbtt_pkg::REG_LED0_CYCLE_TIME, cyc0);
    write_reg(lbtt_pkg::REG_LED1_ON_TIME, on1);
    write_reg(lbtt_pkg::REG_LED1_CYCLE_TIME, cyc1);
    write_reg(lbtt_pkg::REG_LED2_ON_TIME, on2);
    write_reg(lbtt_pkg::REG_LED2_CYCLE_TIME, cyc2);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int phase);
    for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
      calm = (phase == 1) && (i >= 100) && (i < 250);
      if (phase == 2 && i == 100) hold_off_req = 1'b1;
      push_item(random_item());
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    lbtt_pkg::op_t reload_op;
    items_sent   = 0;
    calm         = 1'b0;
    hold_off_req = 1'b0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    item       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: first tick clears phases, unused op, reload extremes, restart timing
    configure_leds(8'd2, 8'd5, 8'd1, 8'd3, 8'd3, 8'd3);
    push_item(make_item(lbtt_pkg::OP_TICK, 8'h00));
    push_item(make_item(lbtt_pkg::OP_TICK, 8'hFF));
    push_item(make_item(OP_UNUSED, 8'hFF));
    push_item(make_item(OP_UNUSED, 8'h00));
    reload_op = lbtt_pkg::OP_RELOAD_KEEPALIVE;
    repeat (5) begin
      push_item(make_item(reload_op, 8'hFF));
      reload_op = reload_op.next();
    end
    reload_op = lbtt_pkg::OP_RELOAD_KEEPALIVE;
    repeat (5) begin
      push_item(make_item(reload_op, 8'h00));
      reload_op = reload_op.next();
    end
    push_item(make_item(lbtt_pkg::OP_RESTART, 8'h00));
    repeat (3) push_item(make_item(lbtt_pkg::OP_TICK, 8'h00));
    push_item(make_item(lbtt_pkg::OP_RELOAD_KEEPALIVE, 8'h01));
    push_item(make_item(lbtt_pkg::OP_RESTART, 8'hFF));
    repeat (2) push_item(make_item(lbtt_pkg::OP_TICK, 8'hAA));
    run_random(0);

    // on-time longer than cycle, zero on-time, zero cycle time
    configure_leds(8'd0, 8'd4, 8'd4, 8'd2, 8'd1, 8'd0);
    run_random(1);

    // register extremes, with a long result hold-off
    configure_leds(8'd255, 8'd255, 8'd0, 8'd0, 8'd7, 8'd9);
    run_random(2);

    configure_leds(8'($urandom_range(10)), 8'($urandom_range(10)),
                   8'($urandom_range(10)), 8'($urandom_range(10)),
                   8'($urandom_range(10)), 8'($urandom_range(10)));
    run_random(3);

    // Drain and give the verdict
    item_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d item transactions over four LED timing setups in %0d cycles;",
             items_sent, cycles);
    $display("predicted %0d second pulses and %0d shutdown requests, %0d mismatches.",
             seconds_seen, shutdowns_seen, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("** led_blink_and_timeout_ticker: PASSED **");
    end else begin
      $display("** led_blink_and_timeout_ticker: FAILED **");
    end
    $finish;
  end

endmodule
